[sv/okpp_pkg.sv]
// Shared types, constants and the CRC-24 byte step for the key packet pruner.
package okpp_pkg;

  localparam logic [23:0] CRC_INIT = 24'hB704CE;
  localparam logic [24:0] CRC_POLY = 25'h1864CFB;
  localparam int unsigned FIELD_COUNT_WIDTH = 24;

  localparam logic [5:0] TAG_PUBKEY = 6'd6;
  localparam logic [5:0] TAG_USERID = 6'd13;
  localparam logic [5:0] TAG_SIG    = 6'd2;

  localparam logic [2:0] SEEN_PUBKEY = 3'b001;
  localparam logic [2:0] SEEN_USERID = 3'b010;
  localparam logic [2:0] SEEN_SIG    = 3'b100;
  localparam logic [2:0] SEEN_ALL    = 3'b111;

  localparam logic [1:0] OLD_LEN_ONE  = 2'd0;
  localparam logic [1:0] OLD_LEN_TWO  = 2'd1;
  localparam logic [1:0] OLD_LEN_FOUR = 2'd2;
  localparam logic [1:0] OLD_LEN_NONE = 2'd3;

  localparam logic [7:0] NEW_LEN_TWO_MIN  = 8'd192;
  localparam logic [7:0] NEW_LEN_PART_MIN = 8'd224;
  localparam logic [7:0] NEW_LEN_FIVE     = 8'hFF;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NEWLEN,
    PH_TWOLEN,
    PH_MULTI,
    PH_BODY,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OLD_LEN,
    ST_NEW_LEN
  } status_e;

  // One classified item passed from the parser to the CRC/count stage.
  typedef struct packed {
    logic [7:0]  data;
    logic        keep;
    logic        hdr;
    logic [5:0]  tag;
    logic [31:0] blen;
    logic        done;
    status_e     status;
  } item_t;

  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

[sv/okpp_front.sv]
// Header parser: tracks packet framing and classifies each incoming byte.
module okpp_front
  import okpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output item_t      item_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  left_q, left_d;
  logic [4:0]  first_q, first_d;
  logic [5:0]  tag_q, tag_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] remain_q, remain_d;
  logic [2:0]  seen_q, seen_d;
  status_e     err_q, err_d;

  logic        hdr;
  logic        pend;
  logic [31:0] hlen;
  logic [2:0]  tag_bit;

  // Header completion and packet end for the current byte
  always_comb begin
    hdr  = 1'b0;
    pend = 1'b0;
    hlen = '0;
    case (phase_q)
      PH_NEWLEN: begin
        if (data_byte_i < NEW_LEN_TWO_MIN) begin
          hdr  = 1'b1;
          hlen = {24'h0, data_byte_i};
        end
      end
      PH_TWOLEN: begin
        hdr  = 1'b1;
        hlen = {19'h0, first_q, data_byte_i} + 32'd192;
      end
      PH_MULTI: begin
        if (left_q == 3'd1) begin
          hdr  = 1'b1;
          hlen = {acc_q[23:0], data_byte_i};
        end
      end
      PH_BODY: begin
        pend = (remain_q == 32'd1);
      end
      default: begin
      end
    endcase
    if (hdr && hlen == '0) begin
      pend = 1'b1;
    end
  end

  always_comb begin
    case (tag_q)
      TAG_PUBKEY: tag_bit = SEEN_PUBKEY;
      TAG_USERID: tag_bit = SEEN_USERID;
      TAG_SIG:    tag_bit = SEEN_SIG;
      default:    tag_bit = 3'b000;
    endcase
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    first_d  = first_q;
    tag_d    = tag_q;
    acc_d    = acc_q;
    remain_d = remain_q;
    seen_d   = seen_q;
    err_d    = err_q;
    case (phase_q)
      PH_HEADER: begin
        if (data_byte_i[6]) begin
          tag_d   = data_byte_i[5:0];
          phase_d = PH_NEWLEN;
        end else begin
          tag_d = {2'b00, data_byte_i[5:2]};
          acc_d = '0;
          case (data_byte_i[1:0])
            OLD_LEN_ONE:  left_d = 3'd1;
            OLD_LEN_TWO:  left_d = 3'd2;
            OLD_LEN_FOUR: left_d = 3'd4;
            default:      left_d = left_q;
          endcase
          if (data_byte_i[1:0] == OLD_LEN_NONE) begin
            err_d   = ST_OLD_LEN;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_MULTI;
          end
        end
      end
      PH_NEWLEN: begin
        if (data_byte_i < NEW_LEN_TWO_MIN) begin
          phase_d = phase_q;
        end else if (data_byte_i < NEW_LEN_PART_MIN) begin
          first_d = data_byte_i[4:0];
          phase_d = PH_TWOLEN;
        end else if (data_byte_i == NEW_LEN_FIVE) begin
          left_d  = 3'd4;
          acc_d   = '0;
          phase_d = PH_MULTI;
        end else begin
          err_d   = ST_NEW_LEN;
          phase_d = PH_DONE;
        end
      end
      PH_MULTI: begin
        acc_d  = {acc_q[23:0], data_byte_i};
        left_d = left_q - 3'd1;
      end
      PH_BODY: begin
        remain_d = remain_q - 32'd1;
        if (pend) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
      end
    endcase
    if (hdr) begin
      seen_d   = seen_q | tag_bit;
      remain_d = hlen;
      phase_d  = pend ? PH_HEADER : PH_BODY;
    end
    if (phase_q != PH_DONE && phase_d != PH_DONE &&
        ((pend && seen_d == SEEN_ALL) || last_byte_i)) begin
      phase_d = PH_DONE;
    end
  end

  assign item_o.data   = data_byte_i;
  assign item_o.keep   = (phase_q != PH_DONE);
  assign item_o.hdr    = hdr;
  assign item_o.tag    = hdr ? tag_q : 6'd0;
  assign item_o.blen   = hdr ? hlen : 32'd0;
  assign item_o.done   = (phase_d == PH_DONE);
  assign item_o.status = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= '0;
      first_q  <= '0;
      tag_q    <= '0;
      acc_q    <= '0;
      remain_q <= '0;
      seen_q   <= '0;
      err_q    <= ST_OK;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      first_q  <= first_d;
      tag_q    <= tag_d;
      acc_q    <= acc_d;
      remain_q <= remain_d;
      seen_q   <= seen_d;
      err_q    <= err_d;
    end
  end

endmodule

[sv/okpp_queue.sv]
// Two-entry item queue between the parser and the CRC/count stage.
module okpp_queue
  import okpp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  nonempty_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign nonempty_o = (count_q != 2'd0);
  assign item_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/okpp_back.sv]
// CRC-24 and kept-byte counter, plus the result register.
module okpp_back
  import okpp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        keep_o,
  output logic        header_end_o,
  output logic [5:0]  hdr_tag_o,
  output logic [31:0] body_length_o,
  output logic [23:0] crc_o,
  output logic [23:0] kept_count_o,
  output logic        done_res_o,
  output logic [1:0]  status_o
);

  localparam int unsigned KW =
    (COUNT_WIDTH < FIELD_COUNT_WIDTH) ? COUNT_WIDTH : FIELD_COUNT_WIDTH;

  logic          valid_q, valid_d;
  logic [23:0]   crc_q, crc_d;
  logic [KW-1:0] count_q, count_d;
  item_t         res_q;

  assign pop_o = avail_i && (!valid_q || !out_stall_i);

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (item_i.keep) begin
      crc_d = crc_byte(crc_q, item_i.data);
      if (count_q != {KW{1'b1}}) begin
        count_d = count_q + KW'(1);
      end
    end
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      crc_q   <= CRC_INIT;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        crc_q   <= crc_d;
        count_q <= count_d;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign keep_o        = res_q.keep;
  assign header_end_o  = res_q.hdr;
  assign hdr_tag_o     = res_q.tag;
  assign body_length_o = res_q.blen;
  assign crc_o         = crc_q;
  assign kept_count_o  = FIELD_COUNT_WIDTH'(count_q);
  assign done_res_o    = res_q.done;
  assign status_o      = res_q.status;

endmodule

[sv/openpgp_key_packet_pruner_unit.sv]
// Top level of the OpenPGP key packet pruner with CRC-24.
//
// Input channel: one octet of decoded key data per item (data_byte_i, with
// last_byte_i on the final octet), on in_valid_i / in_stall_o. Output channel:
// one result item per input item, on out_valid_o / out_stall_i, in order.
// The parser classifies each octet in the cycle it is accepted and writes it
// to a two-entry queue; the CRC/count stage takes one item per cycle from the
// queue into the result register while out_stall_i is low, a rate set by the
// single-octet CRC step and the one-octet-per-cycle header parser. An item
// passes the queue and then the result register before out_valid_o rises.
// A stalled result holds its fields; the queue keeps taking input until it is
// full, then in_stall_o rises. After reset the parser waits for a packet
// header, the CRC holds 0xB704CE and the kept count is zero. Once done_res_o
// is set, later octets give keep 0 and the final CRC and count until reset.
module openpgp_key_packet_pruner_unit
  import okpp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        keep_o,
  output logic        header_end_o,
  output logic [5:0]  hdr_tag_o,
  output logic [31:0] body_length_o,
  output logic [23:0] crc_o,
  output logic [23:0] kept_count_o,
  output logic        done_res_o,
  output logic [1:0]  status_o
);

  logic  accept;
  logic  full;
  logic  pop;
  logic  avail;
  item_t front_item;
  item_t queue_item;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  okpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  okpp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .item_i     (front_item),
    .full_o     (full),
    .pop_i      (pop),
    .item_o     (queue_item),
    .nonempty_o (avail)
  );

  okpp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (avail),
    .item_i        (queue_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .keep_o        (keep_o),
    .header_end_o  (header_end_o),
    .hdr_tag_o     (hdr_tag_o),
    .body_length_o (body_length_o),
    .crc_o         (crc_o),
    .kept_count_o  (kept_count_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o)
  );

endmodule
